/* design/i2cseq_pkg.sv */
// Shared types and constants for the I2C serial EEPROM transaction sequencer.
// Used by i2cseq_ctrl and i2c_eeprom_transaction_sequencer_core; no dependencies.
`default_nettype none

package i2cseq_pkg;

    // Page buffer geometry.
    localparam int BUFFER_BYTES = 32;
    localparam int BUF_IDX_W    = $clog2(BUFFER_BYTES);
    localparam int LEN_W        = 6;
    localparam logic [LEN_W-1:0] BUFFER_BYTES_LEN = LEN_W'(BUFFER_BYTES);

    // Input commands.
    typedef enum logic [1:0] {
        CMD_BEGIN_WRITE = 2'd0,
        CMD_BEGIN_READ  = 2'd1,
        CMD_LOAD        = 2'd2,
        CMD_STATUS      = 2'd3
    } cmd_t;

    // Status events reported by the bus engine.
    typedef enum logic [3:0] {
        ST_START      = 4'd0,
        ST_REPSTART   = 4'd1,
        ST_ADDRW_ACK  = 4'd2,
        ST_ADDRW_NACK = 4'd3,
        ST_TX_ACK     = 4'd4,
        ST_TX_NACK    = 4'd5,
        ST_ADDRR_ACK  = 4'd6,
        ST_ADDRR_NACK = 4'd7,
        ST_RX_ACK     = 4'd8,
        ST_RX_NACK    = 4'd9,
        ST_OTHER      = 4'd10
    } bus_status_t;

    // Bus actions requested from the engine.
    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_START   = 3'd1,
        ACT_SEND    = 3'd2,
        ACT_RD_ACK  = 3'd3,
        ACT_RD_NACK = 3'd4,
        ACT_STOP    = 3'd5
    } action_t;

    // Completion status for a successful transaction.
    localparam logic [3:0] STATUS_OK = 4'd0;

    // Sequencer phases, one-hot.
    typedef enum logic [9:0] {
        PH_IDLE    = 10'b00_0000_0001,
        PH_W_START = 10'b00_0000_0010,
        PH_W_SLA   = 10'b00_0000_0100,
        PH_ADDR_HI = 10'b00_0000_1000,
        PH_ADDR_LO = 10'b00_0001_0000,
        PH_DATA    = 10'b00_0010_0000,
        PH_R_START = 10'b00_0100_0000,
        PH_R_SLA   = 10'b00_1000_0000,
        PH_RX_ACK  = 10'b01_0000_0000,
        PH_RX_NACK = 10'b10_0000_0000
    } phase_t;

    // One input transaction.
    typedef struct packed {
        logic [1:0]       command;
        logic [15:0]      mem_address;
        logic [LEN_W-1:0] transfer_length;
        logic [7:0]       write_data;
        logic [4:0]       buffer_index;
        logic [3:0]       bus_status;
        logic [7:0]       received_byte;
    } in_item_t;

    // One result transaction.
    typedef struct packed {
        logic [2:0] bus_action;
        logic [7:0] bus_byte;
        logic       read_valid;
        logic [7:0] read_data;
        logic [4:0] read_index;
        logic       done_res;
        logic [3:0] status;
    } out_item_t;

    // What the controller makes of one input transaction.
    typedef struct packed {
        logic      has_result;
        out_item_t item;
    } step_t;

endpackage

`default_nettype wire

/* design/i2cseq_ctrl.sv */
// Phase machine, transfer counters and page buffer of the EEPROM sequencer.
// Depends on i2cseq_pkg.
`default_nettype none

module i2cseq_ctrl
    import i2cseq_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     item_advance,
    input  wire in_item_t item,
    input  wire logic [6:0] device_address,
    output step_t         step
);

    phase_t                    phase_reg, phase_next;
    logic                      is_read_reg, is_read_next;
    logic [15:0]               target_address_reg, target_address_next;
    logic [LEN_W-1:0]          bytes_left_reg, bytes_left_next;
    logic [BUF_IDX_W-1:0]      byte_position_reg, byte_position_next;
    logic [7:0]                page_buffer_reg [BUFFER_BYTES];

    logic                      do_fail;
    logic                      do_next_data;
    logic                      do_next_read;
    logic [LEN_W-1:0]          read_left;
    logic [3:0]                capped_status;
    logic [LEN_W-1:0]          sat_len;

    // Next state and result for the transaction in the input register.
    always_comb begin
        step                = '0;
        phase_next          = phase_reg;
        is_read_next        = is_read_reg;
        target_address_next = target_address_reg;
        bytes_left_next     = bytes_left_reg;
        byte_position_next  = byte_position_reg;
        do_fail             = 1'b0;
        do_next_data        = 1'b0;
        do_next_read        = 1'b0;
        read_left           = bytes_left_reg;

        capped_status = (item.bus_status > ST_OTHER) ? ST_OTHER : item.bus_status;
        sat_len = (item.transfer_length > BUFFER_BYTES_LEN) ? BUFFER_BYTES_LEN
                                                            : item.transfer_length;

        unique case (item.command)
            CMD_BEGIN_WRITE, CMD_BEGIN_READ: begin
                // A begin while busy is dropped without a result.
                if (phase_reg == PH_IDLE) begin
                    is_read_next        = (item.command == CMD_BEGIN_READ);
                    target_address_next = item.mem_address;
                    byte_position_next  = '0;
                    if (item.command == CMD_BEGIN_READ && sat_len == '0) begin
                        bytes_left_next = LEN_W'(1);
                    end else begin
                        bytes_left_next = sat_len;
                    end
                    step.has_result      = 1'b1;
                    step.item.bus_action = ACT_START;
                    phase_next           = PH_W_START;
                end
            end
            CMD_LOAD: begin
                // The buffer write happens in the clocked block below.
            end
            CMD_STATUS: begin
                unique case (phase_reg)
                    PH_W_START: begin
                        if (item.bus_status == ST_START || item.bus_status == ST_REPSTART) begin
                            step.has_result      = 1'b1;
                            step.item.bus_action = ACT_SEND;
                            step.item.bus_byte   = {device_address, 1'b0};
                            phase_next           = PH_W_SLA;
                        end else begin
                            do_fail = 1'b1;
                        end
                    end
                    PH_W_SLA: begin
                        // Address nack: poll the device with another start.
                        if (item.bus_status == ST_ADDRW_NACK) begin
                            step.has_result      = 1'b1;
                            step.item.bus_action = ACT_START;
                            phase_next           = PH_W_START;
                        end else if (item.bus_status == ST_ADDRW_ACK) begin
                            step.has_result      = 1'b1;
                            step.item.bus_action = ACT_SEND;
                            step.item.bus_byte   = target_address_reg[15:8];
                            phase_next           = PH_ADDR_HI;
                        end else begin
                            do_fail = 1'b1;
                        end
                    end
                    PH_ADDR_HI: begin
                        if (item.bus_status == ST_TX_ACK) begin
                            step.has_result      = 1'b1;
                            step.item.bus_action = ACT_SEND;
                            step.item.bus_byte   = target_address_reg[7:0];
                            phase_next           = PH_ADDR_LO;
                        end else begin
                            do_fail = 1'b1;
                        end
                    end
                    PH_ADDR_LO: begin
                        if (item.bus_status != ST_TX_ACK) begin
                            do_fail = 1'b1;
                        end else if (is_read_reg) begin
                            step.has_result      = 1'b1;
                            step.item.bus_action = ACT_START;
                            phase_next           = PH_R_START;
                        end else begin
                            do_next_data = 1'b1;
                        end
                    end
                    PH_DATA: begin
                        if (item.bus_status == ST_TX_ACK) begin
                            do_next_data = 1'b1;
                        end else begin
                            do_fail = 1'b1;
                        end
                    end
                    PH_R_START: begin
                        if (item.bus_status == ST_REPSTART) begin
                            step.has_result      = 1'b1;
                            step.item.bus_action = ACT_SEND;
                            step.item.bus_byte   = {device_address, 1'b1};
                            phase_next           = PH_R_SLA;
                        end else begin
                            do_fail = 1'b1;
                        end
                    end
                    PH_R_SLA: begin
                        if (item.bus_status == ST_ADDRR_ACK) begin
                            do_next_read = 1'b1;
                        end else begin
                            do_fail = 1'b1;
                        end
                    end
                    PH_RX_ACK: begin
                        if (item.bus_status == ST_RX_ACK) begin
                            step.item.read_valid = 1'b1;
                            step.item.read_data  = item.received_byte;
                            step.item.read_index = byte_position_reg;
                            byte_position_next   = byte_position_reg + 1'b1;
                            if (bytes_left_reg != '0) begin
                                read_left = bytes_left_reg - 1'b1;
                            end
                            bytes_left_next = read_left;
                            do_next_read    = 1'b1;
                        end else begin
                            do_fail = 1'b1;
                        end
                    end
                    PH_RX_NACK: begin
                        if (item.bus_status == ST_RX_NACK) begin
                            step.has_result      = 1'b1;
                            step.item.read_valid = 1'b1;
                            step.item.read_data  = item.received_byte;
                            step.item.read_index = byte_position_reg;
                            step.item.bus_action = ACT_STOP;
                            step.item.done_res   = 1'b1;
                            step.item.status     = STATUS_OK;
                            byte_position_next   = byte_position_reg + 1'b1;
                            bytes_left_next      = '0;
                            phase_next           = PH_IDLE;
                        end else begin
                            do_fail = 1'b1;
                        end
                    end
                    default: begin
                        // Idle: a status event is ignored.
                    end
                endcase
            end
            default: begin
            end
        endcase

        // Next data byte of a write, or the closing stop when none are left.
        if (do_next_data) begin
            step.has_result = 1'b1;
            if (bytes_left_reg == '0) begin
                step.item.bus_action = ACT_STOP;
                step.item.done_res   = 1'b1;
                step.item.status     = STATUS_OK;
                phase_next           = PH_IDLE;
            end else begin
                step.item.bus_action = ACT_SEND;
                step.item.bus_byte   = page_buffer_reg[byte_position_reg];
                byte_position_next   = byte_position_reg + 1'b1;
                bytes_left_next      = bytes_left_reg - 1'b1;
                phase_next           = PH_DATA;
            end
        end

        // Next read: the last byte is read with a nack.
        if (do_next_read) begin
            step.has_result = 1'b1;
            if (read_left > LEN_W'(1)) begin
                step.item.bus_action = ACT_RD_ACK;
                phase_next           = PH_RX_ACK;
            end else begin
                step.item.bus_action = ACT_RD_NACK;
                phase_next           = PH_RX_NACK;
            end
        end

        // Unexpected status: stop with the error code.
        if (do_fail) begin
            step.has_result      = 1'b1;
            step.item.bus_action = ACT_STOP;
            step.item.bus_byte   = '0;
            step.item.done_res   = 1'b1;
            step.item.status     = capped_status + 4'd1;
            phase_next           = PH_IDLE;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_IDLE;
            is_read_reg        <= 1'b0;
            target_address_reg <= '0;
            bytes_left_reg     <= '0;
            byte_position_reg  <= '0;
        end else if (item_advance) begin
            phase_reg          <= phase_next;
            is_read_reg        <= is_read_next;
            target_address_reg <= target_address_next;
            bytes_left_reg     <= bytes_left_next;
            byte_position_reg  <= byte_position_next;
        end
    end

    // Page buffer loads.
    always_ff @(posedge aclk) begin
        if (item_advance && item.command == CMD_LOAD) begin
            page_buffer_reg[item.buffer_index[BUF_IDX_W-1:0]] <= item.write_data;
        end
    end

endmodule

`default_nettype wire

/* design/i2c_eeprom_transaction_sequencer_core.sv */
// Top level of the I2C serial EEPROM transaction sequencer.
// Depends on i2cseq_pkg and i2cseq_ctrl.
//
//   Channel  Handshake             Payload       Direction
//   s_       s_valid / s_ready     s_item        in  (commands, bus status)
//   m_       m_valid / m_ready     m_item        out (bus actions, read bytes)
//   cfg_     cfg_valid / cfg_ready cfg_data      in  (device address)
//
// Each transaction is registered on acceptance and decided in the next cycle;
// its result then passes through the result register before it is valid.
// One transaction per cycle is sustained unless a result is stalled at m_.
// Reset returns the sequencer to idle and the device address to 0x50.
// A stalled result holds the input register, which then stalls s_ready.
`default_nettype none

module i2c_eeprom_transaction_sequencer_core
    import i2cseq_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire in_item_t   s_item,
    output logic            m_valid,
    input  wire logic       m_ready,
    output out_item_t       m_item,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [6:0] cfg_data
);

    logic       in_valid_reg;
    in_item_t   in_item_reg;
    logic       out_valid_reg;
    out_item_t  out_item_reg;
    logic [6:0] device_address_reg;
    logic       in_advance;
    logic       out_free;
    step_t      step;

    // Stage handshakes.
    assign out_free   = !out_valid_reg || m_ready;
    assign in_advance = in_valid_reg && (!step.has_result || out_free);
    assign s_ready    = !in_valid_reg || in_advance;
    assign cfg_ready  = 1'b1;
    assign m_valid    = out_valid_reg;
    assign m_item     = out_item_reg;

    // Device address register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            device_address_reg <= 7'd80;
        end else if (cfg_valid) begin
            device_address_reg <= cfg_data;
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    // Sequencer logic.
    i2cseq_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .item_advance   (in_advance),
        .item           (in_item_reg),
        .device_address (device_address_reg),
        .step           (step)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_advance && step.has_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && in_advance && step.has_result) begin
            out_item_reg <= step.item;
        end
    end

`ifndef SYNTHESIS
    // A waiting result is never overwritten.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !(in_advance && step.has_result))
        else $error("result register overwritten while stalled");

    // Completion is only reported with a stop.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.done_res) |-> (m_item.bus_action == ACT_STOP))
        else $error("done without stop action");

    // A received byte travels with a read or the closing stop.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.read_valid) |->
            (m_item.bus_action == ACT_RD_ACK || m_item.bus_action == ACT_RD_NACK ||
             m_item.bus_action == ACT_STOP))
        else $error("read byte with unexpected action");

    // The input register only refuses when it holds an undelivered transaction.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && step.has_result && out_valid_reg))
        else $error("input stalled without cause");
`endif

endmodule

`default_nettype wire
